// ===== src/timed_task_scheduler_top_assert.svh =====
// Assertion macros for the timed task scheduler.
// Used by timed_task_scheduler_top; empty under synthesis.
`ifndef TIMED_TASK_SCHEDULER_TOP_ASSERT_SVH
`define TIMED_TASK_SCHEDULER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TTS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define TTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TTS_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define TTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== src/tts_pkg.sv =====
// Shared types and constants of the timed task scheduler.
// No dependencies.
package tts_pkg;
   localparam int FifoDepth  = 16;
   localparam int DelayDepth = 16;
   localparam int FifoIdxW   = $clog2(FifoDepth);
   localparam int FifoCntW   = $clog2(FifoDepth + 1);
   localparam int DelIdxW    = $clog2(DelayDepth);
   localparam int DelCntW    = $clog2(DelayDepth + 1);

   typedef enum logic [1:0] {
      REQ_POST_NOW   = 2'd0,
      REQ_POST_LATER = 2'd1,
      REQ_FETCH      = 2'd2,
      REQ_SHUTDOWN   = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DISPATCH, ST_SCAN, ST_DECIDE, ST_SHIFT, ST_OUT
   } ctrl_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;     // capture request
      logic post_now;     // append to FIFO
      logic post_later;   // place in delayed store
      logic shutdown;     // set quit flag
      logic scan_start;   // reset scan
      logic scan_step;    // compare one delayed entry
      logic decide;       // choose winner, build result
      logic shift_step;   // move one FIFO entry toward head
      logic shift_done;   // close a FIFO pop
      logic out_load;     // result register load
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      req_kind_type kind;
      logic         quit;
      logic         scan_last;
      logic         pop_fifo;   // decided to pop FIFO head
      logic         shift_last;
      logic         out_busy;   // result waiting
   } stat_type;
endpackage

// ===== src/tts_ctrl.sv =====
// Controller state machine of the timed task scheduler.
// Depends on tts_pkg.
module tts_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  tts_pkg::stat_type stat,
   output logic              req_ready,
   output tts_pkg::cmd_type  cmd
);
   import tts_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_fire) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            if (stat.kind == REQ_FETCH && !stat.quit) state_in = ST_SCAN;
            else state_in = ST_OUT;
         end
         ST_SCAN:     if (stat.scan_last) state_in = ST_DECIDE;
         ST_DECIDE:   state_in = stat.pop_fifo ? ST_SHIFT : ST_OUT;
         ST_SHIFT:    if (stat.shift_last) state_in = ST_OUT;
         ST_OUT:      if (!stat.out_busy) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE:     cmd.load_req = req_fire;
         ST_DISPATCH: begin
            cmd.post_now   = (stat.kind == REQ_POST_NOW);
            cmd.post_later = (stat.kind == REQ_POST_LATER);
            cmd.shutdown   = (stat.kind == REQ_SHUTDOWN);
            cmd.scan_start = 1'b1;
         end
         ST_SCAN:     cmd.scan_step = 1'b1;
         ST_DECIDE:   cmd.decide = 1'b1;
         ST_SHIFT:    begin
            cmd.shift_step = 1'b1;
            cmd.shift_done = stat.shift_last;
         end
         ST_OUT:      cmd.out_load = !stat.out_busy;
         default:     cmd = '0;
      endcase
   end
endmodule

// ===== src/tts_datapath.sv =====
// Datapath of the timed task scheduler: FIFO, delayed store, scan, result.
// Depends on tts_pkg; driven by tts_ctrl.
module tts_datapath (
   input  logic              clock,
   input  logic              reset,
   input  tts_pkg::cmd_type  cmd,
   output tts_pkg::stat_type stat,
   input  logic [1:0]        req_type,
   input  logic [15:0]       req_task_id,
   input  logic [31:0]       req_delay_ms,
   input  logic [31:0]       req_now_ms,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   output logic              rsp_run_valid,
   output logic [15:0]       rsp_run_task,
   output logic              rsp_final_flag,
   output logic [31:0]       rsp_sleep_ms,
   output logic              rsp_post_rejected
);
   import tts_pkg::*;

   // captured request
   req_kind_type kind_ff;
   logic [15:0]  task_ff;
   logic [31:0]  delay_ff, now_ff;

   // stores
   logic [31:0]          fifo_order_mem [FifoDepth];
   logic [15:0]          fifo_task_mem  [FifoDepth];
   logic [FifoCntW-1:0]  fifo_count_ff;
   logic [31:0]          del_fire_mem  [DelayDepth];
   logic [31:0]          del_order_mem [DelayDepth];
   logic [15:0]          del_task_mem  [DelayDepth];
   logic [DelayDepth-1:0] del_valid_ff;
   logic [31:0]          order_ff;
   logic                 quit_ff;

   // scan state
   logic [DelCntW-1:0]   scan_ff;
   logic                 best_ok_ff;
   logic [DelIdxW-1:0]   best_idx_ff;
   logic [31:0]          best_fire_ff, best_order_ff;
   logic [FifoCntW-1:0]  shift_ff;

   // staged result of the request in work
   logic        s_run_ff, s_final_ff, s_rej_ff;
   logic [15:0] s_task_ff;
   logic [31:0] s_sleep_ff;

   // result
   logic        r_valid_ff, r_run_ff, r_final_ff, r_rej_ff;
   logic [15:0] r_task_ff;
   logic [31:0] r_sleep_ff;
   logic        n_run, n_final, n_rej;
   logic [15:0] n_task;
   logic [31:0] n_sleep;

   // free slot in delayed store
   logic               free_ok;
   logic [DelIdxW-1:0] free_idx;
   always_comb begin
      free_ok = 1'b0;
      free_idx = '0;
      for (int i = DelayDepth - 1; i >= 0; i--) begin
         if (!del_valid_ff[i]) begin
            free_ok = 1'b1;
            free_idx = DelIdxW'(i);
         end
      end
   end

   logic [DelIdxW-1:0] scan_idx;
   logic [31:0]        cur_fire, cur_order;
   logic               better, fifo_full, due, fifo_older;
   assign scan_idx  = scan_ff[DelIdxW-1:0];
   assign cur_fire  = del_fire_mem[scan_idx];
   assign cur_order = del_order_mem[scan_idx];
   assign better = del_valid_ff[scan_idx] && (!best_ok_ff || cur_fire < best_fire_ff ||
                   (cur_fire == best_fire_ff && cur_order < best_order_ff));
   assign fifo_full = (fifo_count_ff == FifoCntW'(FifoDepth));
   assign due = best_ok_ff && (now_ff >= best_fire_ff);
   assign fifo_older = (fifo_count_ff != '0) && (fifo_order_mem[0] < best_order_ff);

   // result candidate per request
   always_comb begin
      n_run = 1'b0; n_task = '0; n_final = 1'b0; n_sleep = '0; n_rej = 1'b0;
      case (kind_ff)
         REQ_POST_NOW:   n_rej = fifo_full;
         REQ_POST_LATER: n_rej = !free_ok;
         REQ_FETCH: begin
            if (quit_ff) n_final = 1'b1;
            else if (due && !fifo_older) begin
               n_run = 1'b1; n_task = del_task_mem[best_idx_ff];
            end else begin
               if (best_ok_ff && !due) n_sleep = best_fire_ff - now_ff;
               if (fifo_count_ff != '0) begin
                  n_run = 1'b1; n_task = fifo_task_mem[0];
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff <= req_kind_type'(req_type);
         task_ff <= req_task_id;
         delay_ff <= req_delay_ms;
         now_ff <= req_now_ms;
      end
      if (cmd.post_now && !fifo_full) begin
         fifo_order_mem[fifo_count_ff[FifoIdxW-1:0]] <= order_ff;
         fifo_task_mem[fifo_count_ff[FifoIdxW-1:0]]  <= task_ff;
      end
      if (cmd.post_later && free_ok) begin
         del_fire_mem[free_idx]  <= now_ff + delay_ff;
         del_order_mem[free_idx] <= order_ff + 32'd1;
         del_task_mem[free_idx]  <= task_ff;
      end
      if (cmd.scan_step && better) begin
         best_idx_ff <= scan_idx;
         best_fire_ff <= cur_fire;
         best_order_ff <= cur_order;
      end
      if (cmd.shift_step && shift_ff < fifo_count_ff) begin
         fifo_order_mem[shift_ff[FifoIdxW-1:0] - FifoIdxW'(1)] <=
            fifo_order_mem[shift_ff[FifoIdxW-1:0]];
         fifo_task_mem[shift_ff[FifoIdxW-1:0] - FifoIdxW'(1)] <=
            fifo_task_mem[shift_ff[FifoIdxW-1:0]];
      end
      // stage while an older result may still wait at the output
      if (cmd.decide || cmd.scan_start) begin
         s_run_ff <= n_run; s_task_ff <= n_task; s_final_ff <= n_final;
         s_sleep_ff <= n_sleep; s_rej_ff <= n_rej;
      end
      if (cmd.out_load) begin
         r_run_ff <= s_run_ff; r_task_ff <= s_task_ff; r_final_ff <= s_final_ff;
         r_sleep_ff <= s_sleep_ff; r_rej_ff <= s_rej_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_count_ff <= '0; del_valid_ff <= '0; order_ff <= '0; quit_ff <= 1'b0;
         scan_ff <= '0; best_ok_ff <= 1'b0; shift_ff <= '0;
         r_valid_ff <= 1'b0;
      end else begin
         if (cmd.post_now && !fifo_full) begin
            fifo_count_ff <= fifo_count_ff + FifoCntW'(1);
            order_ff <= order_ff + 32'd1;
         end
         if (cmd.post_later && free_ok) begin
            del_valid_ff[free_idx] <= 1'b1;
            order_ff <= order_ff + 32'd1;
         end
         if (cmd.shutdown) quit_ff <= 1'b1;
         if (cmd.scan_start) begin
            scan_ff <= '0; best_ok_ff <= 1'b0;
         end
         if (cmd.scan_step) begin
            scan_ff <= scan_ff + DelCntW'(1);
            if (better) best_ok_ff <= 1'b1;
         end
         if (cmd.decide) begin
            shift_ff <= FifoCntW'(1);
            if (due && !fifo_older) del_valid_ff[best_idx_ff] <= 1'b0;
         end
         if (cmd.shift_step) shift_ff <= shift_ff + FifoCntW'(1);
         if (cmd.shift_done) fifo_count_ff <= fifo_count_ff - FifoCntW'(1);
         if (cmd.out_load) r_valid_ff <= 1'b1;
         else if (rsp_tready) r_valid_ff <= 1'b0;
      end
   end

   assign stat.kind       = kind_ff;
   assign stat.quit       = quit_ff;
   assign stat.scan_last  = (scan_ff == DelCntW'(DelayDepth - 1));
   assign stat.pop_fifo   = n_run && !(due && !fifo_older);
   assign stat.shift_last = (shift_ff >= fifo_count_ff) ||
                            (shift_ff == FifoCntW'(FifoDepth - 1));
   assign stat.out_busy   = r_valid_ff && !rsp_tready;

   assign rsp_tvalid        = r_valid_ff;
   assign rsp_run_valid     = r_run_ff;
   assign rsp_run_task      = r_task_ff;
   assign rsp_final_flag    = r_final_ff;
   assign rsp_sleep_ms      = r_sleep_ff;
   assign rsp_post_rejected = r_rej_ff;
endmodule

// ===== src/timed_task_scheduler_top.sv =====
// Timed task scheduler: one request in, one result out.
// Posts, shutdown and a fetch after shutdown go from dispatch straight to the result load;
// a fetch first scans all DelayDepth delayed entries and decides, and shifts the FIFO when it pops.
// One request at a time: the next is accepted once the result has loaded into the output
// register; a waiting result stalls the controller only there.
// Reset (synchronous, active high) empties both stores and clears counter and quit flag.
module timed_task_scheduler_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // req_type
   input  logic [79:0] req_tdata,   // [15:0] task_id, [47:16] delay_ms, [79:48] now_ms
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata    // [0] run_valid, [16:1] run_task, [17] final_flag,
                                    // [49:18] sleep_ms, [50] post_rejected, rest zero
);
   import tts_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     req_fire;
   logic        run_valid, final_flag, post_rejected;
   logic [15:0] run_task;
   logic [31:0] sleep_ms;

   assign req_fire = req_tvalid && req_tready;

   tts_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire), .stat(stat),
      .req_ready(req_tready), .cmd(cmd)
   );

   tts_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_type(req_tuser), .req_task_id(req_tdata[15:0]),
      .req_delay_ms(req_tdata[47:16]), .req_now_ms(req_tdata[79:48]),
      .rsp_tready(rsp_tready), .rsp_tvalid(rsp_tvalid),
      .rsp_run_valid(run_valid), .rsp_run_task(run_task),
      .rsp_final_flag(final_flag), .rsp_sleep_ms(sleep_ms),
      .rsp_post_rejected(post_rejected)
   );

   assign rsp_tdata = {5'd0, post_rejected, sleep_ms, final_flag, run_task, run_valid};

`include "timed_task_scheduler_top_assert.svh"

   // a final result never hands out a task
   `TTS_ASSERT_IMPL(a_final_no_run, clock, reset, rsp_tvalid && final_flag, !run_valid, "final run")
   // a waiting result holds its data
   `TTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp changed")
   // accepted request leaves idle next cycle
   `TTS_ASSERT_NEXT(a_busy_after_fire, clock, reset, req_fire, !req_tready, "ready after accept")
endmodule
